/* design/xcc_pkg.sv */
// Package for the XChaCha20 byte stream cipher: sizes, constants, state types
// and the quarter-round and column/diagonal round functions. No dependencies.
package xcc_pkg;

    localparam int unsigned DoubleRoundsDefault = 10;
    localparam int unsigned NumRegs             = 7;
    localparam int unsigned RegIdxW             = 3;
    localparam int unsigned QueueDepth          = 2;

    localparam logic [31:0] Sigma0 = 32'h61707865;
    localparam logic [31:0] Sigma1 = 32'h3320646e;
    localparam logic [31:0] Sigma2 = 32'h79622d32;
    localparam logic [31:0] Sigma3 = 32'h6b206574;

    // Configuration register indexes
    localparam logic [RegIdxW-1:0] RegKey0   = 3'd0;
    localparam logic [RegIdxW-1:0] RegKey1   = 3'd1;
    localparam logic [RegIdxW-1:0] RegKey2   = 3'd2;
    localparam logic [RegIdxW-1:0] RegKey3   = 3'd3;
    localparam logic [RegIdxW-1:0] RegNonce0 = 3'd4;
    localparam logic [RegIdxW-1:0] RegNonce1 = 3'd5;
    localparam logic [RegIdxW-1:0] RegNonce2 = 3'd6;

    typedef logic [15:0][31:0] t_state;

    // Item handed from the front to the back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
        logic       last_in;
    } t_item;

    // Core engine job types
    typedef enum logic [1:0] {
        E_IDLE,
        E_HCHACHA,
        E_BLOCK
    } t_eng_state;

    typedef logic [3:0][31:0] t_quad;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic t_quad quarter(input t_quad q);
        logic [31:0] a, b, c, d;
        a = q[0]; b = q[1]; c = q[2]; d = q[3];
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        quarter = {d, c, b, a};
    endfunction

    // One round: column round when diag is low, diagonal round otherwise
    function automatic t_state one_round(input t_state x, input logic diag);
        t_state y;
        t_quad  q;
        y = x;
        for (int i = 0; i < 4; i++) begin
            if (!diag) begin
                q = quarter({x[12+i], x[8+i], x[4+i], x[i]});
                y[i] = q[0]; y[4+i] = q[1]; y[8+i] = q[2]; y[12+i] = q[3];
            end else begin
                q = quarter({x[12+((i+3)%4)], x[8+((i+2)%4)], x[4+((i+1)%4)], x[i]});
                y[i] = q[0]; y[4+((i+1)%4)] = q[1];
                y[8+((i+2)%4)] = q[2]; y[12+((i+3)%4)] = q[3];
            end
        end
        one_round = y;
    endfunction

endpackage

/* design/xcc_front.sv */
// Front end: accepts items and holds them in a short queue for the back end.
// Depends on xcc_pkg.
module xcc_front
    import xcc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_item i_item,
    output logic  o_q_valid,
    output t_item o_q_item,
    input  logic  i_q_pop
);
    t_item r_mem [QueueDepth];
    logic  r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic  w_push;

    assign o_stall   = (r_cnt == 2'(QueueDepth));
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    // Track fill level
    always_comb begin
        n_cnt = r_cnt + 2'(w_push) - 2'(i_q_pop && o_q_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop && o_q_valid) r_rp <= ~r_rp;
        end
    end

    // Store payload
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_item;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'(QueueDepth))
        else $error("queue overfilled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !o_q_valid) else $error("empty queue shows valid");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !(i_q_pop && o_q_valid)) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("push not counted");
endmodule

/* design/xcc_back.sv */
// Back end: derives the subkey, makes keystream blocks one round per cycle
// and XORs bytes into a registered output. Depends on xcc_pkg.
module xcc_back
    import xcc_pkg::*;
#(
    parameter int unsigned DOUBLE_ROUNDS = DoubleRoundsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [63:0] i_cfg [NumRegs],
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_out
);
    localparam int unsigned Rounds = 2 * DOUBLE_ROUNDS;
    localparam int unsigned RndW   = $clog2(Rounds + 1);

    t_eng_state r_st, n_st;
    t_state     r_x, r_init, r_ks;
    logic [RndW-1:0] r_rnd;
    logic [7:0][31:0] r_subkey;
    logic [63:0] r_ctr, r_tail;
    logic [5:0]  r_pos;
    logic        r_have_blk, r_started;
    logic        r_rs_done;
    logic        r_ov;
    logic [7:0]  r_ob;
    logic        r_ol;
    logic        w_need, w_rekey, w_out_free, w_fire, w_round_done;
    t_state      w_hinit, w_binit, w_kinit, w_rx;

    assign w_out_free   = !r_ov || !i_stall;
    // A restart on the head item is served once; the flag drops when it leaves
    assign w_rekey      = (i_q_item.restart && !r_rs_done) || !r_started;
    assign w_need       = w_rekey || !r_have_blk;
    assign w_fire       = (r_st == E_IDLE) && i_q_valid && !w_need && w_out_free;
    assign o_q_pop      = w_fire;
    assign w_round_done = (r_rnd == RndW'(Rounds - 1));
    assign w_rx         = one_round(r_x, r_rnd[0]);

    // Initial states for HChaCha20 and for a block
    always_comb begin
        w_hinit = '0;
        w_hinit[0] = Sigma0; w_hinit[1] = Sigma1; w_hinit[2] = Sigma2; w_hinit[3] = Sigma3;
        for (int i = 0; i < 4; i++) begin
            w_hinit[4+2*i] = i_cfg[i][31:0];
            w_hinit[5+2*i] = i_cfg[i][63:32];
        end
        w_hinit[12] = i_cfg[RegNonce0][31:0];
        w_hinit[13] = i_cfg[RegNonce0][63:32];
        w_hinit[14] = i_cfg[RegNonce1][31:0];
        w_hinit[15] = i_cfg[RegNonce1][63:32];
        w_binit = '0;
        w_binit[0] = Sigma0; w_binit[1] = Sigma1; w_binit[2] = Sigma2; w_binit[3] = Sigma3;
        for (int i = 0; i < 8; i++) w_binit[4+i] = r_subkey[i];
        w_binit[12] = r_ctr[31:0];
        w_binit[13] = r_ctr[63:32];
        w_binit[14] = r_tail[31:0];
        w_binit[15] = r_tail[63:32];
        // First block after a restart takes the subkey straight from the last round
        w_kinit = '0;
        w_kinit[0] = Sigma0; w_kinit[1] = Sigma1; w_kinit[2] = Sigma2; w_kinit[3] = Sigma3;
        for (int i = 0; i < 4; i++) begin
            w_kinit[4+i] = w_rx[i];
            w_kinit[8+i] = w_rx[12+i];
        end
        w_kinit[12] = r_ctr[31:0];
        w_kinit[13] = r_ctr[63:32];
        w_kinit[14] = r_tail[31:0];
        w_kinit[15] = r_tail[63:32];
    end

    // Next engine state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            E_IDLE: begin
                if (i_q_valid && w_need)
                    n_st = w_rekey ? E_HCHACHA : E_BLOCK;
            end
            E_HCHACHA: if (w_round_done) n_st = E_BLOCK;
            E_BLOCK:   if (w_round_done) n_st = E_IDLE;
            default:   n_st = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= E_IDLE;
        else          r_st <= n_st;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= 1'b0;
            r_have_blk <= 1'b0;
            r_rs_done  <= 1'b0;
            r_ctr      <= '0;
            r_pos      <= '0;
            r_ov       <= 1'b0;
            r_rnd      <= '0;
        end else begin
            if (w_fire) begin
                r_ov      <= 1'b1;
                r_rs_done <= 1'b0;
                r_pos     <= r_pos + 6'd1;
                if (r_pos == 6'd63) r_have_blk <= 1'b0;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            if (r_st == E_IDLE && i_q_valid && w_need) begin
                r_rnd <= '0;
                if (w_rekey) begin
                    r_started  <= 1'b1;
                    r_rs_done  <= 1'b1;
                    r_ctr      <= '0;
                    r_have_blk <= 1'b0;
                end
            end
            if (r_st != E_IDLE) r_rnd <= w_round_done ? '0 : r_rnd + RndW'(1);
            if (r_st == E_BLOCK && w_round_done) begin
                r_have_blk <= 1'b1;
                r_pos      <= '0;
                r_ctr      <= r_ctr + 64'd1;
            end
        end
    end

    // Round datapath
    always_ff @(posedge i_clk) begin
        if (r_st == E_IDLE && i_q_valid && w_need) begin
            if (w_rekey) begin
                r_x    <= w_hinit;
                r_tail <= i_cfg[RegNonce2];
            end else begin
                r_x    <= w_binit;
                r_init <= w_binit;
            end
        end else if (r_st == E_HCHACHA) begin
            if (w_round_done) begin
                r_x    <= w_kinit;
                r_init <= w_kinit;
                for (int i = 0; i < 4; i++) begin
                    r_subkey[i]   <= w_rx[i];
                    r_subkey[4+i] <= w_rx[12+i];
                end
            end else begin
                r_x <= w_rx;
            end
        end else if (r_st == E_BLOCK) begin
            if (w_round_done) begin
                for (int i = 0; i < 16; i++)
                    r_ks[i] <= w_rx[i] + r_init[i];
            end
            r_x <= w_rx;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_ob <= i_q_item.data_byte ^ r_ks[r_pos[5:2]][8*r_pos[1:0] +: 8];
            r_ol <= i_q_item.last_in;
        end
    end

    assign o_valid    = r_ov;
    assign o_out_byte = r_ob;
    assign o_last_out = r_ol;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) w_fire |-> r_have_blk)
        else $error("byte used without keystream");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> (r_ov && $stable(r_ob)))
        else $error("stalled output changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != E_IDLE) |-> !o_q_pop) else $error("pop while busy");
endmodule

/* design/xchacha20_byte_stream_cipher_unit.sv */
// XChaCha20 byte stream cipher top level. Depends on xcc_pkg, xcc_front, xcc_back.
// Each byte is XORed into a registered output. A new block stalls the stream for a
// load step and its rounds (one round per cycle); a restart first runs HChaCha20.
// Throughput: one byte per cycle within a block, while the output is not stalled.
// Reset (synchronous, active low) clears configuration and control registers,
// counter and position; the first item after reset derives the subkey.
module xchacha20_byte_stream_cipher_unit
    import xcc_pkg::*;
#(
    parameter int unsigned DOUBLE_ROUNDS = DoubleRoundsDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_restart,
    input  logic               i_last_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_out_byte,
    output logic               o_last_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [RegIdxW-1:0] i_cfg_index,
    input  logic [63:0]        i_cfg_data
);
    logic [63:0] r_cfg [NumRegs];
    logic  w_qv, w_pop;
    t_item w_qi;
    t_item w_in_item;

    assign o_cfg_ready = 1'b1;
    assign w_in_item   = {i_data_byte, i_restart, i_last_in};

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumRegs; i++) r_cfg[i] <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index) inside
                RegKey0, RegKey1, RegKey2, RegKey3, RegNonce0, RegNonce1, RegNonce2:
                    r_cfg[i_cfg_index] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    xcc_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_item(w_in_item),
        .o_q_valid(w_qv), .o_q_item(w_qi), .i_q_pop(w_pop)
    );

    xcc_back #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_back (
        .i_clk, .i_rst_n, .i_cfg(r_cfg),
        .i_q_valid(w_qv), .i_q_item(w_qi), .o_q_pop(w_pop),
        .o_valid, .i_stall, .o_out_byte, .o_last_out
    );
endmodule
